@@ sv/are_pkg.sv @@
// ============================================================================
// are_pkg - shared types and constants of the arithmetic range encoder
// Code-interval widths, divider sizing, sequencer states and helpers.
// ============================================================================
package are_pkg;

    // Code interval and frequency widths
    localparam int CODE_BITS   = 16;
    localparam int FREQ_BITS   = 14;
    localparam int FOLLOW_BITS = 32;
    localparam int MAX_RESULTS = 16;

    // Derived widths of the narrowing arithmetic
    localparam int SPAN_W = CODE_BITS + 1;
    localparam int PROD_W = SPAN_W + FREQ_BITS;

    // Divider: quotient bits retired per cycle
    localparam int DIV_STEP  = 2;
    localparam int DIV_CYC   = (PROD_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W     = DIV_CYC * DIV_STEP;
    localparam int DIV_CNT_W = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

    // Renormalization counters
    localparam int PASS_W = $clog2(CODE_BITS + 1);
    localparam int EMIT_W = $clog2(MAX_RESULTS + 1);

    // Interval landmarks
    localparam logic [CODE_BITS-1:0] TOP_VAL  = {CODE_BITS{1'b1}};
    localparam logic [CODE_BITS-1:0] HALF_VAL = CODE_BITS'(1) << (CODE_BITS - 1);
    localparam logic [CODE_BITS-1:0] QTR1_VAL = CODE_BITS'(1) << (CODE_BITS - 2);
    localparam logic [CODE_BITS-1:0] QTR3_VAL = QTR1_VAL + HALF_VAL;

    localparam logic [FOLLOW_BITS-1:0] FOLLOW_MAX = {FOLLOW_BITS{1'b1}};

    // Input item modes
    typedef enum logic [1:0] {
        MODE_ENCODE  = 2'd0,
        MODE_FINISH  = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_HI,
        ST_DIV_HI,
        ST_MUL_LO,
        ST_DIV_LO,
        ST_RENORM,
        ST_FLUSH
    } state_t;

    // Saturating increment of the pending follow count
    function automatic logic [FOLLOW_BITS-1:0] sat_inc(input logic [FOLLOW_BITS-1:0] v);
        sat_inc = (v == FOLLOW_MAX) ? v : v + FOLLOW_BITS'(1);
    endfunction

endpackage

@@ sv/arithmetic_range_encoder.sv @@
// ============================================================================
// arithmetic_range_encoder - integer arithmetic encoder, 16-bit code range
// Narrows the code interval per symbol, renormalizes and emits code bits
// together with the count of opposite follow bits owed before each one.
// ============================================================================
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  input   | in        | in_valid / in_ready  | mode, cum_upto, cum_below, total_freq
//  result  | out       | out_valid / out_ready| out_bit, follow_count, last
//
//  An encode item holds in_ready low while the shared multiplier feeds the
//  radix-4 divider twice, then for up to CODE_BITS renormalization passes,
//  one pass per cycle unless a full result register stalls an emitting pass.
//  A finish item holds in_ready low while its held result is flushed.
//  Reset returns the interval to [0, all ones] and clears the follow count.
//  A full result register stalls renormalization on the next emitting pass;
//  in_ready stays low until the item's last result is in the output register.
//
module arithmetic_range_encoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      mode,
    input  logic [are_pkg::FREQ_BITS-1:0]   cum_upto,
    input  logic [are_pkg::FREQ_BITS-1:0]   cum_below,
    input  logic [are_pkg::FREQ_BITS-1:0]   total_freq,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_bit,
    output logic [are_pkg::FOLLOW_BITS-1:0] follow_count,
    output logic                            last
);
    import are_pkg::*;

    // Sequencer and interval state
    state_t               state_reg, state_next;
    logic [CODE_BITS-1:0] low_reg, low_next;
    logic [CODE_BITS-1:0] high_reg, high_next;
    logic [FOLLOW_BITS-1:0] pend_reg, pend_next;

    // Latched symbol bounds and span
    logic [FREQ_BITS-1:0] upto_reg, upto_next;
    logic [FREQ_BITS-1:0] below_reg, below_next;
    logic [FREQ_BITS-1:0] total_reg, total_next;
    logic [SPAN_W-1:0]    span_reg, span_next;

    // Renormalization counters
    logic [PASS_W-1:0]    pass_reg, pass_next;
    logic [EMIT_W-1:0]    emit_reg, emit_next;

    // Held result: the latest emission waits here until we know whether it is last
    logic                   hold_valid_reg, hold_valid_next;
    logic                   hold_bit_reg, hold_bit_next;
    logic [FOLLOW_BITS-1:0] hold_follow_reg, hold_follow_next;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    logic                   out_bit_reg, out_bit_next;
    logic [FOLLOW_BITS-1:0] out_follow_reg, out_follow_next;
    logic                   out_last_reg, out_last_next;

    // Shared multiplier and divider
    logic [FREQ_BITS-1:0] mul_op;
    logic [PROD_W-1:0]    product;
    logic                 div_start;
    logic                 div_done;
    logic [CODE_BITS-1:0] div_quo;

    logic                 in_xfer;
    logic                 out_free;
    logic [CODE_BITS-1:0] diff;
    logic                 cls_lo, cls_hi, cls_mid, loop_end;
    logic [CODE_BITS-1:0] sub_val, low_sub, high_sub;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // One multiplier serves both bounds; the divider registers its product
    assign mul_op    = (state_reg == ST_MUL_HI) ? upto_reg : below_reg;
    assign product   = PROD_W'(span_reg) * PROD_W'(mul_op);
    assign div_start = (state_reg == ST_MUL_HI) || (state_reg == ST_MUL_LO);

    are_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign diff = high_reg - low_reg;

    // Classify the interval for one renormalization pass
    always_comb
    begin
        cls_lo  = (high_reg < HALF_VAL);
        cls_hi  = !cls_lo && (low_reg >= HALF_VAL);
        cls_mid = !cls_lo && !cls_hi && (low_reg >= QTR1_VAL) && (high_reg < QTR3_VAL);
        loop_end = (pass_reg == PASS_W'(CODE_BITS)) || (emit_reg == EMIT_W'(MAX_RESULTS))
                   || !(cls_lo || cls_hi || cls_mid);
        priority if (cls_hi)
            sub_val = HALF_VAL;
        else if (cls_mid)
            sub_val = QTR1_VAL;
        else
            sub_val = '0;
        low_sub  = low_reg - sub_val;
        high_sub = high_reg - sub_val;
    end

    always_comb
    begin
        state_next       = state_reg;
        low_next         = low_reg;
        high_next        = high_reg;
        pend_next        = pend_reg;
        upto_next        = upto_reg;
        below_next       = below_reg;
        total_next       = total_reg;
        span_next        = span_reg;
        pass_next        = pass_reg;
        emit_next        = emit_reg;
        hold_valid_next  = hold_valid_reg;
        hold_bit_next    = hold_bit_reg;
        hold_follow_next = hold_follow_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_bit_next     = out_bit_reg;
        out_follow_next  = out_follow_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    unique case (mode_t'(mode))
                        MODE_ENCODE:
                        begin
                            // Drop an encode item with a zero total
                            if (total_freq != '0)
                            begin
                                upto_next  = cum_upto;
                                below_next = cum_below;
                                total_next = total_freq;
                                span_next  = {1'b0, diff} + SPAN_W'(1);
                                state_next = ST_MUL_HI;
                            end
                        end
                        MODE_FINISH:
                        begin
                            // One more pending bit, then the quarter-selecting bit
                            hold_valid_next  = 1'b1;
                            hold_bit_next    = (low_reg >= QTR1_VAL);
                            hold_follow_next = sat_inc(pend_reg);
                            pend_next        = '0;
                            state_next       = ST_FLUSH;
                        end
                        MODE_RESTART:
                        begin
                            low_next  = '0;
                            high_next = TOP_VAL;
                            pend_next = '0;
                        end
                        MODE_NONE:
                        begin
                        end
                    endcase
                end
            end
            ST_MUL_HI:
                state_next = ST_DIV_HI;
            ST_DIV_HI:
            begin
                if (div_done)
                begin
                    high_next  = low_reg + div_quo - CODE_BITS'(1);
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO:
                state_next = ST_DIV_LO;
            ST_DIV_LO:
            begin
                if (div_done)
                begin
                    low_next   = low_reg + div_quo;
                    pass_next  = '0;
                    emit_next  = '0;
                    state_next = ST_RENORM;
                end
            end
            ST_RENORM:
            begin
                if (loop_end)
                    state_next = ST_FLUSH;
                else if (cls_mid || !hold_valid_reg || out_free)
                begin
                    if (cls_mid)
                        pend_next = sat_inc(pend_reg);
                    else
                    begin
                        // Push the previous emission out, hold the new one
                        if (hold_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_bit_next    = hold_bit_reg;
                            out_follow_next = hold_follow_reg;
                            out_last_next   = 1'b0;
                        end
                        hold_valid_next  = 1'b1;
                        hold_bit_next    = cls_hi;
                        hold_follow_next = pend_reg;
                        pend_next        = '0;
                        emit_next        = emit_reg + EMIT_W'(1);
                    end
                    low_next  = {low_sub[CODE_BITS-2:0], 1'b0};
                    high_next = {high_sub[CODE_BITS-2:0], 1'b1};
                    pass_next = pass_reg + PASS_W'(1);
                end
            end
            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                    state_next = ST_IDLE;
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_bit_next    = hold_bit_reg;
                    out_follow_next = hold_follow_reg;
                    out_last_next   = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            low_reg        <= '0;
            high_reg       <= TOP_VAL;
            pend_reg       <= '0;
            pass_reg       <= '0;
            emit_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            pend_reg       <= pend_next;
            pass_reg       <= pass_next;
            emit_reg       <= emit_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        upto_reg        <= upto_next;
        below_reg       <= below_next;
        total_reg       <= total_next;
        span_reg        <= span_next;
        hold_bit_reg    <= hold_bit_next;
        hold_follow_reg <= hold_follow_next;
        out_bit_reg     <= out_bit_next;
        out_follow_reg  <= out_follow_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_bit      = out_bit_reg;
    assign follow_count = out_follow_reg;
    assign last         = out_last_reg;

`ifndef NO_ASSERTIONS
    a_hold_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !hold_valid_reg)
        else $error("held result left behind in idle");

    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RENORM) |-> (emit_reg <= EMIT_W'(MAX_RESULTS)))
        else $error("emission count beyond limit");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RENORM) |-> (pass_reg <= PASS_W'(CODE_BITS)))
        else $error("renormalization pass count beyond limit");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_HI || state_reg == ST_DIV_LO))
        else $error("divider finished outside a divide state");

    a_renorm_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RENORM && $past(state_reg) == ST_DIV_LO) |->
            (!hold_valid_reg && emit_reg == '0))
        else $error("renormalization started with a held result");
`endif

endmodule

@@ sv/are_div.sv @@
// ============================================================================
// are_div - iterative restoring divider
// Divides a product by the model total, DIV_STEP quotient bits per cycle.
// Only the low CODE_BITS quotient bits are kept.
// ============================================================================
module are_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [are_pkg::PROD_W-1:0]    dividend,
    input  logic [are_pkg::FREQ_BITS-1:0] divisor,
    output logic                          done,
    output logic [are_pkg::CODE_BITS-1:0] quotient
);
    import are_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [FREQ_BITS-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [CODE_BITS-1:0] quo_reg, quo_next;

    logic [FREQ_BITS-1:0] rem_v;
    logic [DIV_W-1:0]     dvd_v;
    logic [CODE_BITS-1:0] quo_v;
    logic [FREQ_BITS:0]   trial;
    logic [FREQ_BITS:0]   diff;

    // Shift in one dividend bit per step, subtract when it fits
    always_comb
    begin
        rem_v = rem_reg;
        dvd_v = dvd_reg;
        quo_v = quo_reg;
        trial = '0;
        diff  = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {rem_v, dvd_v[DIV_W-1]};
            dvd_v = dvd_v << 1;
            diff  = trial - {1'b0, divisor};
            if (trial >= {1'b0, divisor})
            begin
                rem_v = diff[FREQ_BITS-1:0];
                quo_v = {quo_v[CODE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_v = trial[FREQ_BITS-1:0];
                quo_v = {quo_v[CODE_BITS-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = DIV_W'(dividend);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = rem_v;
            dvd_next = dvd_v;
            quo_next = quo_v;
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_CYC - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
